/* src/msa_pkg.sv */
// Shared constants, types and helpers of the moving average filter.
// No dependencies; used by msa_div and the top level.
package msa_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int PTR_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W      = CNT_W;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_W      = 5;
   localparam int SUM_W      = SAMPLE_W + PTR_W + 1;
   localparam int MAG_W      = SUM_W - 1;
   localparam int STEP_W     = $clog2(MAG_W + 1);

   localparam logic [CSR_W-1:0] WINDOW_RESET = CSR_W'(4);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic start;
      logic negate;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
   } div_stat_type;

   // zero counts as one, anything above the ring depth saturates
   function automatic logic [LEN_W-1:0] eff_len(input logic [CSR_W-1:0] v);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (int'(v) > MAX_WINDOW) begin
         r = LEN_W'(MAX_WINDOW);
      end else begin
         r = LEN_W'(v);
      end
      return r;
   endfunction

endpackage

/* src/moving_average_filter_top.sv */
// Moving average filter, top level: sample ring, serial window sum, divider.
// Depends on msa_pkg and msa_div.
//
//  channel | direction | payload                         | handshake
//  --------+-----------+---------------------------------+----------------
//  req     | in        | tdata: sample; tuser: start seq | tvalid / tready
//  rsp     | out       | tdata: average                  | tvalid / tready
//  csr     | in        | wr_data: window length          | wr_en, no wait
//
// A request that completes a window reads len ring entries, one per cycle,
// for the sum (len = effective window length), then msa_div yields one
// quotient bit per cycle. A request that yields no result leaves the block
// idle. Reset (synchronous) restores a window length of 4, an empty history
// and no pending result. The result register holds while rsp_tready is low;
// a new request is taken once the divider hands over.
module moving_average_filter_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample (signed)
   input  logic        req_tuser,   // [0] start_sequence
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] average (signed)
   // window length register
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // [4:0] window_length
);

   localparam int SW = msa_pkg::SAMPLE_W;

   msa_pkg::state_type              state_ff, state_in;
   logic [msa_pkg::PTR_W-1:0]       wp_ff, wp_in;
   logic [msa_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic [msa_pkg::CSR_W-1:0]       len_cfg_ff;
   logic [msa_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [msa_pkg::LEN_W-1:0]       issue_ff, issue_in;
   logic [msa_pkg::PTR_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [SW-1:0]                   rd_data_ff;
   logic signed [msa_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [SW-1:0]                   rsp_data_ff, rsp_data_in;

   logic [SW-1:0]                   ring_mem [msa_pkg::MAX_WINDOW];

   logic                            req_acc;
   logic                            rsp_free;
   logic                            issuing;
   logic [msa_pkg::PTR_W-1:0]       wr_addr;
   logic [msa_pkg::PTR_W-1:0]       rd_addr;
   logic [msa_pkg::CNT_W-1:0]       fill_base;
   logic [msa_pkg::LEN_W-1:0]       len_eff;
   logic [msa_pkg::SUM_W-1:0]       sum_neg;
   logic [msa_pkg::MAG_W-1:0]       sum_mag;
   msa_pkg::div_ctl_type            div_ctl;
   msa_pkg::div_stat_type           div_stat;
   logic [SW-1:0]                   div_q;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign issuing  = issue_ff != len_ff;
   assign len_eff  = msa_pkg::eff_len(len_cfg_ff);

   // a start flag rewinds the ring before the sample goes in
   assign wr_addr   = req_tuser ? '0 : wp_ff;
   assign fill_base = req_tuser ? '0 : fill_ff;

   // walk backwards from the newest sample
   assign rd_addr = (rd_idx_ff == '0) ? msa_pkg::PTR_W'(msa_pkg::MAX_WINDOW - 1)
                                      : rd_idx_ff - msa_pkg::PTR_W'(1);

   assign sum_neg = -sum_ff;
   assign sum_mag = sum_ff[msa_pkg::SUM_W-1] ? sum_neg[msa_pkg::MAG_W-1:0]
                                             : sum_ff[msa_pkg::MAG_W-1:0];

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      issue_in      = issue_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = 1'b0;
      sum_in        = sum_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_ctl       = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         msa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               wp_in = (wr_addr == msa_pkg::PTR_W'(msa_pkg::MAX_WINDOW - 1)) ? '0
                     : wr_addr + msa_pkg::PTR_W'(1);
               fill_in = (fill_base == msa_pkg::CNT_W'(msa_pkg::MAX_WINDOW)) ? fill_base
                       : fill_base + msa_pkg::CNT_W'(1);
               len_in    = len_eff;
               issue_in  = '0;
               rd_idx_in = wp_in;
               sum_in    = '0;
               if (fill_in >= len_eff) begin
                  state_in = msa_pkg::ST_SUM;
               end
            end
         end
         msa_pkg::ST_SUM: begin
            if (issuing) begin
               issue_in  = issue_ff + msa_pkg::LEN_W'(1);
               rd_idx_in = rd_addr;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + {{(msa_pkg::SUM_W-SW){rd_data_ff[SW-1]}}, rd_data_ff};
            end
            if (!issuing && !rd_vld_ff) begin
               div_ctl.start  = 1'b1;
               div_ctl.negate = sum_ff[msa_pkg::SUM_W-1];
               state_in       = msa_pkg::ST_DIV;
            end
         end
         msa_pkg::ST_DIV: begin
            if (!div_stat.busy && rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = div_q;
               state_in      = msa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msa_pkg::ST_IDLE;
         wp_ff         <= '0;
         fill_ff       <= '0;
         len_cfg_ff    <= msa_pkg::WINDOW_RESET;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            len_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample ring: one write per request, one registered read per cycle
   always_ff @(posedge clock) begin
      if (req_acc) begin
         ring_mem[wr_addr] <= req_tdata;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   msa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (sum_mag),
      .divisor  (len_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/msa_div.sv */
// Bit-serial restoring divider: magnitude of window sum by window length.
// One quotient bit per cycle through a shift register. Uses msa_pkg.
module msa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  msa_pkg::div_ctl_type           ctl,
   input  logic [msa_pkg::MAG_W-1:0]      dividend,
   input  logic [msa_pkg::LEN_W-1:0]      divisor,
   output msa_pkg::div_stat_type          stat,
   output logic [msa_pkg::SAMPLE_W-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic [msa_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [msa_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [msa_pkg::MAG_W-1:0]     shf_ff, shf_in;
   logic [msa_pkg::LEN_W-1:0]     dsr_ff, dsr_in;
   logic                          neg_ff, neg_in;
   logic [msa_pkg::LEN_W:0]       trial;
   logic [msa_pkg::LEN_W:0]       diff;
   logic                          fits;
   logic [msa_pkg::SAMPLE_W-1:0]  qmag;

   assign trial = {rem_ff, shf_ff[msa_pkg::MAG_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = msa_pkg::STEP_W'(msa_pkg::MAG_W);
         rem_in  = '0;
         shf_in  = dividend;
         dsr_in  = divisor;
         neg_in  = ctl.negate;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits LEN_W bits
         rem_in  = fits ? diff[msa_pkg::LEN_W-1:0] : trial[msa_pkg::LEN_W-1:0];
         shf_in  = {shf_ff[msa_pkg::MAG_W-2:0], fits};
         cnt_in  = cnt_ff - msa_pkg::STEP_W'(1);
         busy_in = cnt_ff != msa_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign qmag      = shf_ff[msa_pkg::SAMPLE_W-1:0];
   assign quotient  = neg_ff ? (~qmag) + msa_pkg::SAMPLE_W'(1) : qmag;
   assign stat.busy = busy_ff;

endmodule

/* src/msa_chk.sv */
// Port-level checker for the moving average filter, bound to the top level.
// Depends on nothing but the top level's ports.
module msa_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending after reset");

   // a result never rises straight after an accepted request
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared right after a request");

   // requests are held off while the divider is running
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("request taken while a result was in progress");

endmodule

bind moving_average_filter_top msa_chk u_chk (.*);
